// ===== hw/rtl/wsd_pkg.sv =====
// ============================================================================
// wsd_pkg: shared types and constants of the WebSocket frame deframer
// Holds the parse phases, byte kinds, event codes, opcodes and the result
// word that travels from the parser through the result queue.
// ============================================================================
package wsd_pkg;

  // Width of the kept frame length; a longer 64-bit length keeps its low bits.
  localparam int LENGTH_BITS = 64;

  // Result queue between the parser and the output channel.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Header constants.
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;
  localparam logic [3:0] EXT16_BYTES  = 4'd2;
  localparam logic [3:0] EXT64_BYTES  = 4'd8;
  localparam logic [3:0] MASK_BYTES   = 4'd4;

  // Frame opcodes.
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // Message type codes.
  localparam logic [1:0] MT_NONE = 2'd0;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_PAY  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_PING = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_MSG_END  = 3'd1,
    EV_CLOSE    = 3'd2,
    EV_ORPHAN   = 3'd3,
    EV_UNKNOWN  = 3'd4,
    EV_LINK     = 3'd5
  } event_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      byte_kind;
    logic       frame_last;
    logic       message_last;
    logic [1:0] message_type;
    event_t     event_res;
  } res_t;

  // Write side of the result queue.
  typedef struct packed {
    logic valid;
    res_t data;
  } push_t;

endpackage

// ===== hw/rtl/wsd_if.sv =====
// ============================================================================
// wsd_if: channel interfaces of the WebSocket frame deframer
// The input channel carries link bytes, the output channel carries results.
// ============================================================================
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       link_failed;

  modport source (output valid, output in_byte, output link_failed, input ready);
  modport sink   (input valid, input in_byte, input link_failed, output ready);
endinterface

interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] byte_kind;
  logic       frame_last;
  logic       message_last;
  logic [1:0] message_type;
  logic [2:0] event_res;

  modport source (output valid, output out_byte, output byte_kind, output frame_last,
                  output message_last, output message_type, output event_res,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_kind, input frame_last,
                  input message_last, input message_type, input event_res,
                  output ready);
endinterface

// ===== hw/rtl/wsd_front.sv =====
// ============================================================================
// wsd_front: frame parser
// Accepts one link byte a cycle while the result queue has room, walks the frame
// header, unmasks payload and forms at most one result word per byte for the result queue.
// ============================================================================
module wsd_front (
  input  logic             clk,
  input  logic             rst_n,
  wsd_in_if.sink           in_ch,
  input  logic             space,
  output wsd_pkg::push_t   push
);

  wsd_pkg::phase_t                     phase_r, phase_nxt;
  logic [3:0]                          ext_r, ext_nxt;
  logic                                fin_r, fin_nxt;
  logic [3:0]                          op_r, op_nxt;
  logic                                masked_r, masked_nxt;
  logic [wsd_pkg::LENGTH_BITS-1:0]     rem_r, rem_nxt;
  logic [31:0]                         key_r, key_nxt;
  logic [1:0]                          mpos_r, mpos_nxt;
  logic                                in_msg_r, in_msg_nxt;
  logic [1:0]                          ctype_r, ctype_nxt;

  logic accept;

  assign in_ch.ready = space;
  assign accept      = in_ch.valid && space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wsd_pkg::PH_HDR0;
      ext_r    <= '0;
      fin_r    <= 1'b0;
      op_r     <= '0;
      masked_r <= 1'b0;
      mpos_r   <= '0;
      in_msg_r <= 1'b0;
      ctype_r  <= wsd_pkg::MT_NONE;
    end else begin
      phase_r  <= phase_nxt;
      ext_r    <= ext_nxt;
      fin_r    <= fin_nxt;
      op_r     <= op_nxt;
      masked_r <= masked_nxt;
      mpos_r   <= mpos_nxt;
      in_msg_r <= in_msg_nxt;
      ctype_r  <= ctype_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    key_r <= key_nxt;
  end

  always_comb begin
    logic [7:0]      b;
    logic [7:0]      pay_b;
    logic [7:0]      key_b;
    logic            hdr_done;
    logic            do_end;
    logic [7:0]      end_b;
    wsd_pkg::kind_t  kind;
    wsd_pkg::kind_t  end_k;
    logic [1:0]      dtype;
    logic [1:0]      mt;
    logic            ml;
    wsd_pkg::event_t ev;
    logic            im;
    logic [1:0]      ct;

    phase_nxt  = phase_r;
    ext_nxt    = ext_r;
    fin_nxt    = fin_r;
    op_nxt     = op_r;
    masked_nxt = masked_r;
    rem_nxt    = rem_r;
    key_nxt    = key_r;
    mpos_nxt   = mpos_r;
    in_msg_nxt = in_msg_r;
    ctype_nxt  = ctype_r;

    push.valid             = 1'b0;
    push.data.out_byte     = '0;
    push.data.byte_kind    = wsd_pkg::KIND_NONE;
    push.data.frame_last   = 1'b0;
    push.data.message_last = 1'b0;
    push.data.message_type = wsd_pkg::MT_NONE;
    push.data.event_res    = wsd_pkg::EV_NONE;

    b        = in_ch.in_byte;
    hdr_done = 1'b0;
    do_end   = 1'b0;
    end_b    = '0;
    end_k    = wsd_pkg::KIND_NONE;

    // Payload kind and data type of the frame now held.
    case (op_r) inside
      wsd_pkg::OP_TEXT, wsd_pkg::OP_BIN: kind = wsd_pkg::KIND_DATA;
      wsd_pkg::OP_CONT: kind = in_msg_r ? wsd_pkg::KIND_DATA : wsd_pkg::KIND_NONE;
      wsd_pkg::OP_PING: kind = wsd_pkg::KIND_PING;
      default:          kind = wsd_pkg::KIND_NONE;
    endcase
    dtype = (op_r == wsd_pkg::OP_TEXT || op_r == wsd_pkg::OP_BIN) ? op_r[1:0] : ctype_r;

    case (mpos_r)
      2'd0:    key_b = key_r[31:24];
      2'd1:    key_b = key_r[23:16];
      2'd2:    key_b = key_r[15:8];
      default: key_b = key_r[7:0];
    endcase
    pay_b = masked_r ? (b ^ key_b) : b;

    if (accept && in_ch.link_failed) begin
      push.valid          = 1'b1;
      push.data.frame_last = 1'b1;
      push.data.event_res = wsd_pkg::EV_LINK;
      phase_nxt  = wsd_pkg::PH_HDR0;
      ext_nxt    = '0;
      mpos_nxt   = '0;
      rem_nxt    = '0;
      in_msg_nxt = 1'b0;
      ctype_nxt  = wsd_pkg::MT_NONE;
    end else if (accept) begin
      unique case (phase_r)
        wsd_pkg::PH_HDR0: begin
          fin_nxt   = b[7];
          op_nxt    = b[3:0];
          phase_nxt = wsd_pkg::PH_HDR1;
        end
        wsd_pkg::PH_HDR1: begin
          masked_nxt = b[7];
          rem_nxt    = '0;
          key_nxt    = '0;
          if (b[6:0] == wsd_pkg::LEN_EXT16) begin
            ext_nxt   = wsd_pkg::EXT16_BYTES;
            phase_nxt = wsd_pkg::PH_EXT;
          end else if (b[6:0] == wsd_pkg::LEN_EXT64) begin
            ext_nxt   = wsd_pkg::EXT64_BYTES;
            phase_nxt = wsd_pkg::PH_EXT;
          end else begin
            rem_nxt = wsd_pkg::LENGTH_BITS'(b[6:0]);
            if (b[7]) begin
              ext_nxt   = wsd_pkg::MASK_BYTES;
              phase_nxt = wsd_pkg::PH_MASK;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        wsd_pkg::PH_EXT: begin
          rem_nxt = {rem_r[wsd_pkg::LENGTH_BITS-9:0], b};
          ext_nxt = ext_r - 4'd1;
          if (ext_nxt == '0) begin
            if (masked_r) begin
              ext_nxt   = wsd_pkg::MASK_BYTES;
              phase_nxt = wsd_pkg::PH_MASK;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        wsd_pkg::PH_MASK: begin
          key_nxt = {key_r[23:0], b};
          ext_nxt = ext_r - 4'd1;
          if (ext_nxt == '0) begin
            hdr_done = 1'b1;
          end
        end
        wsd_pkg::PH_PAY: begin
          mpos_nxt = mpos_r + 2'd1;
          rem_nxt  = rem_r - wsd_pkg::LENGTH_BITS'(1);
          if (rem_nxt == '0) begin
            do_end = 1'b1;
            end_b  = pay_b;
            end_k  = kind;
          end else if (kind != wsd_pkg::KIND_NONE) begin
            push.valid             = 1'b1;
            push.data.out_byte     = pay_b;
            push.data.byte_kind    = kind;
            push.data.message_type = (kind == wsd_pkg::KIND_DATA) ? dtype : wsd_pkg::MT_NONE;
          end
        end
        default: begin
          phase_nxt = wsd_pkg::PH_HDR0;
        end
      endcase
    end

    // Header complete: a zero-length frame ends right here.
    if (hdr_done) begin
      mpos_nxt = '0;
      if (rem_nxt == '0) begin
        do_end = 1'b1;
      end else begin
        phase_nxt = wsd_pkg::PH_PAY;
      end
    end

    mt = (end_k == wsd_pkg::KIND_DATA) ? dtype : wsd_pkg::MT_NONE;
    ml = 1'b0;
    ev = wsd_pkg::EV_NONE;
    im = in_msg_r;
    ct = ctype_r;
    case (op_r) inside
      wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT, wsd_pkg::OP_BIN: begin
        if (op_r == wsd_pkg::OP_CONT && !in_msg_r) begin
          ev = wsd_pkg::EV_ORPHAN;
        end else begin
          if (op_r != wsd_pkg::OP_CONT) begin
            ct = op_r[1:0];
            im = 1'b1;
          end
          if (fin_r) begin
            ml = 1'b1;
            mt = ct;
            ev = wsd_pkg::EV_MSG_END;
            im = 1'b0;
          end
        end
      end
      wsd_pkg::OP_CLOSE: begin
        ev = wsd_pkg::EV_CLOSE;
        im = 1'b0;
      end
      wsd_pkg::OP_PING, wsd_pkg::OP_PONG: begin
        ev = wsd_pkg::EV_NONE;
      end
      default: begin
        ev = wsd_pkg::EV_UNKNOWN;
        im = 1'b0;
      end
    endcase
    if (!im) begin
      ct = wsd_pkg::MT_NONE;
    end

    if (do_end) begin
      push.valid             = 1'b1;
      push.data.out_byte     = (end_k == wsd_pkg::KIND_NONE) ? 8'd0 : end_b;
      push.data.byte_kind    = end_k;
      push.data.frame_last   = 1'b1;
      push.data.message_last = ml;
      push.data.message_type = mt;
      push.data.event_res    = ev;
      in_msg_nxt = im;
      ctype_nxt  = ct;
      phase_nxt  = wsd_pkg::PH_HDR0;
      ext_nxt    = '0;
      mpos_nxt   = '0;
    end
  end

endmodule

// ===== hw/rtl/wsd_queue.sv =====
// ============================================================================
// wsd_queue: result queue
// A short register queue between the parser and the output channel, so that
// either side can stall without stopping the other.
// ============================================================================
module wsd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  wsd_pkg::push_t push,
  output logic           space,
  wsd_out_if.source      out_ch
);

  wsd_pkg::res_t             mem_r [wsd_pkg::QDEPTH];
  logic [wsd_pkg::QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [wsd_pkg::QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [wsd_pkg::QAW:0]     count_r, count_nxt;
  logic                      do_push;
  logic                      do_pop;
  wsd_pkg::res_t             head;

  assign space   = (count_r != (wsd_pkg::QAW+1)'(wsd_pkg::QDEPTH));
  assign do_push = push.valid && space;
  assign do_pop  = out_ch.valid && out_ch.ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == wsd_pkg::QAW'(wsd_pkg::QDEPTH-1)) ? '0 :
                   wr_ptr_r + wsd_pkg::QAW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == wsd_pkg::QAW'(wsd_pkg::QDEPTH-1)) ? '0 :
                   rd_ptr_r + wsd_pkg::QAW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + (wsd_pkg::QAW+1)'(1);
      2'b01:   count_nxt = count_r - (wsd_pkg::QAW+1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.data;
    end
  end

  assign head                = mem_r[rd_ptr_r];
  assign out_ch.valid        = (count_r != '0);
  assign out_ch.out_byte     = head.out_byte;
  assign out_ch.byte_kind    = head.byte_kind;
  assign out_ch.frame_last   = head.frame_last;
  assign out_ch.message_last = head.message_last;
  assign out_ch.message_type = head.message_type;
  assign out_ch.event_res    = head.event_res;

endmodule

// ===== hw/rtl/websocket_frame_deframer.sv =====
// ============================================================================
// websocket_frame_deframer: WebSocket receive-side frame parser
// Parses link bytes into unmasked payload words with frame and message events.
// ============================================================================
// A result word is offered on out_ch in the cycle after the byte that causes
// it is accepted, or later while older words still wait in the queue.
// Throughput: one byte per cycle; the four-word result queue keeps input
// flowing while the output side stalls, and ready drops only when it is full.
// Reset (synchronous, rst_n low) returns the parser to the first header byte
// and empties the queue.
module websocket_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  wsd_in_if.sink     in_ch,
  wsd_out_if.source  out_ch
);

  // The front end takes one word per cycle whenever the queue has room. It
  // tracks the header phase, the remaining payload length, the mask key and
  // the open-message state, and forms at most one result word per byte.
  wsd_pkg::push_t push;
  logic           space;

  wsd_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .space (space),
    .push  (push)
  );

  // The back end is a small queue of result words. Its head drives the
  // output channel directly, so a stalled consumer never blocks the parser
  // until the queue is full.
  wsd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .space  (space),
    .out_ch (out_ch)
  );

endmodule

// ===== hw/rtl/wsd_checker.sv =====
// ============================================================================
// wsd_checker: port-level checks of the WebSocket frame deframer
// Watches the output channel for handshake and result-word consistency.
// ============================================================================
module wsd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] byte_kind,
  input logic       frame_last,
  input logic       message_last,
  input logic [1:0] message_type,
  input logic [2:0] event_res
);

  // A stalled word stays offered and unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_kind)
      && $stable(frame_last) && $stable(message_last) && $stable(message_type)
      && $stable(event_res))
    else $error("output word changed while stalled");

  // Events are reported only on the word that ends a frame.
  a_event_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_res != 3'(wsd_pkg::EV_NONE)) |-> frame_last)
    else $error("event outside frame end");

  // A word that carries no byte ends a frame and shows a zero byte.
  a_none_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (byte_kind == 2'(wsd_pkg::KIND_NONE)) |-> frame_last && (out_byte == 8'd0))
    else $error("empty word malformed");

  // A message end comes with its event and never on ping payload.
  a_msg_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && message_last |-> (event_res == 3'(wsd_pkg::EV_MSG_END))
      && (byte_kind != 2'(wsd_pkg::KIND_PING)) && (message_type != wsd_pkg::MT_NONE))
    else $error("message end malformed");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_byte     (out_ch.out_byte),
  .byte_kind    (out_ch.byte_kind),
  .frame_last   (out_ch.frame_last),
  .message_last (out_ch.message_last),
  .message_type (out_ch.message_type),
  .event_res    (out_ch.event_res)
);

// ===== verif/tb_websocket_frame_deframer.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_websocket_frame_deframer: self-checking bench of the WebSocket deframer
// Drives link bytes through the input channel, predicts every result word
// in a frame tracker and compares each accepted result field by field.
// ============================================================================

import wsd_pkg::*;

// Only the low LENGTH_BITS of a frame length are kept.
localparam logic [63:0] LEN_KEEP = {64{1'b1}} >> (64 - LENGTH_BITS);

// Follows the frame and message state of the link and holds the result words
// that the deframer still owes.
class link_frame_tracker;
  localparam int MAX_REPORTS = 10;

  phase_t      parse_ph;
  logic [3:0]  ext_left;
  logic        fin_bit;
  logic [3:0]  opcode;
  logic        masked;
  logic [63:0] remaining;
  logic [31:0] mask_key;
  logic [1:0]  mask_pos;
  logic        in_msg;
  logic [1:0]  msg_type;
  res_t        awaited_words[$];
  int          mismatches;

  function new();
    parse_ph  = PH_HDR0;
    ext_left  = '0;
    fin_bit   = 1'b0;
    opcode    = OP_CONT;
    masked    = 1'b0;
    remaining = '0;
    mask_key  = '0;
    mask_pos  = '0;
    in_msg    = 1'b0;
    msg_type  = MT_NONE;
    mismatches = 0;
  endfunction

  function res_t make_word(logic [7:0] b, kind_t k, logic fl, logic ml, logic [1:0] mt,
                           event_t ev);
    res_t w;
    w.out_byte     = b;
    w.byte_kind    = k;
    w.frame_last   = fl;
    w.message_last = ml;
    w.message_type = mt;
    w.event_res    = ev;
    return w;
  endfunction

  // Payload of data frames is delivered, ping payload is tagged, the rest dropped.
  function kind_t payload_kind();
    if (opcode == OP_TEXT || opcode == OP_BIN) return KIND_DATA;
    if (opcode == OP_CONT && in_msg) return KIND_DATA;
    if (opcode == OP_PING) return KIND_PING;
    return KIND_NONE;
  endfunction

  function logic [1:0] stream_type();
    return (opcode == OP_TEXT || opcode == OP_BIN) ? opcode[1:0] : msg_type;
  endfunction

  function void close_frame(logic [7:0] b, kind_t k);
    logic       ml;
    logic [1:0] mt;
    event_t     ev;
    ml = 1'b0;
    mt = MT_NONE;
    ev = EV_NONE;
    if (k != KIND_NONE) mt = (k == KIND_DATA) ? stream_type() : MT_NONE;
    if (opcode <= OP_BIN) begin
      if (opcode == OP_CONT && !in_msg) begin
        ev = EV_ORPHAN;
      end else begin
        if (opcode != OP_CONT) begin
          msg_type = opcode[1:0];
          in_msg   = 1'b1;
        end
        if (fin_bit) begin
          ml     = 1'b1;
          mt     = msg_type;
          ev     = EV_MSG_END;
          in_msg = 1'b0;
        end
      end
    end else if (opcode == OP_CLOSE) begin
      ev     = EV_CLOSE;
      in_msg = 1'b0;
    end else if (opcode == OP_PING || opcode == OP_PONG) begin
      ev = EV_NONE;
    end else begin
      ev     = EV_UNKNOWN;
      in_msg = 1'b0;
    end
    if (!in_msg) msg_type = MT_NONE;
    awaited_words.push_back(make_word((k == KIND_NONE) ? 8'h00 : b, k, 1'b1, ml, mt, ev));
    parse_ph = PH_HDR0;
    ext_left = '0;
    mask_pos = '0;
  endfunction

  function void finish_header();
    mask_pos = '0;
    if (remaining == 64'd0) close_frame(8'h00, KIND_NONE);
    else parse_ph = PH_PAY;
  endfunction

  // Advances the tracker by one accepted link word.
  function void note_link_word(logic [7:0] b_in, logic lf);
    logic [7:0]  b;
    logic [6:0]  len7;
    logic [31:0] key_sh;
    kind_t       k;
    b = b_in;
    if (lf) begin
      awaited_words.push_back(make_word(8'h00, KIND_NONE, 1'b1, 1'b0, MT_NONE, EV_LINK));
      parse_ph  = PH_HDR0;
      ext_left  = '0;
      mask_pos  = '0;
      remaining = '0;
      in_msg    = 1'b0;
      msg_type  = MT_NONE;
      return;
    end
    case (parse_ph)
      PH_HDR0: begin
        fin_bit  = b[7];
        opcode   = b[3:0];
        parse_ph = PH_HDR1;
      end
      PH_HDR1: begin
        len7      = b[6:0];
        masked    = b[7];
        remaining = '0;
        mask_key  = '0;
        if (len7 == LEN_EXT16) begin
          ext_left = EXT16_BYTES;
          parse_ph = PH_EXT;
        end else if (len7 == LEN_EXT64) begin
          ext_left = EXT64_BYTES;
          parse_ph = PH_EXT;
        end else begin
          remaining = {57'd0, len7};
          if (masked) begin
            ext_left = MASK_BYTES;
            parse_ph = PH_MASK;
          end else begin
            finish_header();
          end
        end
      end
      PH_EXT: begin
        remaining = ((remaining << 8) | {56'd0, b}) & LEN_KEEP;
        ext_left  = ext_left - 4'd1;
        if (ext_left == 4'd0) begin
          if (masked) begin
            ext_left = MASK_BYTES;
            parse_ph = PH_MASK;
          end else begin
            finish_header();
          end
        end
      end
      PH_MASK: begin
        mask_key = {mask_key[23:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left == 4'd0) finish_header();
      end
      PH_PAY: begin
        if (masked) begin
          key_sh = mask_key << {mask_pos, 3'b000};
          b      = b ^ key_sh[31:24];
        end
        mask_pos  = mask_pos + 2'd1;
        k         = payload_kind();
        remaining = (remaining - 64'd1) & LEN_KEEP;
        if (remaining == 64'd0) begin
          close_frame(b, k);
        end else if (k != KIND_NONE) begin
          awaited_words.push_back(make_word(b, k, 1'b0, 1'b0,
                                            (k == KIND_DATA) ? stream_type() : MT_NONE,
                                            EV_NONE));
        end
      end
      default: parse_ph = PH_HDR0;
    endcase
  endfunction

  function void check_result_word(res_t got);
    res_t want;
    logic bad;
    if (awaited_words.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] unexpected result word %h, nothing awaited", $time, got);
      return;
    end
    want = awaited_words.pop_front();
    bad = (got.out_byte !== want.out_byte) || (got.byte_kind !== want.byte_kind) ||
          (got.frame_last !== want.frame_last) || (got.message_last !== want.message_last) ||
          (got.message_type !== want.message_type) || (got.event_res !== want.event_res);
    if (bad) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("[%0t] expected byte=%h kind=%0d fl=%0b ml=%0b type=%0d ev=%0d", $time,
                 want.out_byte, want.byte_kind, want.frame_last, want.message_last,
                 want.message_type, want.event_res);
        $display("[%0t]   actual byte=%h kind=%0d fl=%0b ml=%0b type=%0d ev=%0d", $time,
                 got.out_byte, got.byte_kind, got.frame_last, got.message_last,
                 got.message_type, got.event_res);
      end
    end
  endfunction
endclass

module tb_websocket_frame_deframer;

  // Longest legal quiet stretch is the receiver hold-off below, plus random
  // gaps at 74 percent idling; the limit is far above both.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 16;
  // Bytes actually sent for one frame's payload; longer frames are cut short
  // with a link failure before this is reached.
  localparam int PAYLOAD_CAP    = 400;
  localparam int PHASE_WORDS    = 633;
  localparam logic [3:0] OP_RSVD_TOP = 4'hF;

  logic clk;
  logic rst_n;

  wsd_in_if  in_ch ();
  wsd_out_if out_ch ();

  websocket_frame_deframer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  link_frame_tracker tracker;

  // Idling rates, written only by the stimulus process.
  int src_idle_pct;
  int sink_idle_pct;
  int words_sent;
  // A hold-off is requested by bumping stall_req; the receiver counts it out.
  int stall_req;
  int stall_seen;
  int hold_left;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: checks each accepted result word against the tracker, then
  // decides whether to take the next one. A pending hold-off request keeps ready
  // low until its count runs out, so the internal queue fills and the input stalls.
  initial begin
    out_ch.ready <= 1'b0;
    stall_seen = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        tracker.check_result_word(res_t'({out_ch.out_byte, out_ch.byte_kind, out_ch.frame_last,
                                          out_ch.message_last, out_ch.message_type,
                                          out_ch.event_res}));
      if (stall_seen != stall_req) begin
        stall_seen = stall_req;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Watchdog: ends the run when no word moves on either channel for too long.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Offers one link word, with random idle cycles before it, and waits until
  // the deframer takes it. Acceptance is judged on the values seen at the edge.
  task automatic send_word(input logic [7:0] b, input logic lf);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.in_byte     <= b;
    in_ch.link_failed <= lf;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_link_word(b, lf);
    words_sent++;
  endtask

  function automatic logic [7:0] first_hdr(input logic fin, input logic [3:0] op);
    return {fin, 3'b000, op};
  endfunction

  // Sends one frame. enc selects the length form: 0 seven-bit, 1 sixteen-bit,
  // 2 sixty-four-bit. When cut_at is not negative, the word at that position
  // is replaced by a link failure and the rest of the frame is never sent.
  task automatic send_frame(input logic fin, input logic [3:0] op, input logic [63:0] len,
                            input int enc, input logic masked, input int cut_at);
    logic [7:0]  hdr_q[$];
    logic [31:0] key;
    logic [2:0]  rsv;
    logic [6:0]  len7;
    int          i;
    int          total;
    key = $urandom;
    rsv = 3'($urandom_range(7));
    case (enc)
      0:       len7 = len[6:0];
      1:       len7 = LEN_EXT16;
      default: len7 = LEN_EXT64;
    endcase
    hdr_q.push_back({fin, rsv, op});
    hdr_q.push_back({masked, len7});
    if (enc == 1) begin
      hdr_q.push_back(len[15:8]);
      hdr_q.push_back(len[7:0]);
    end else if (enc == 2) begin
      for (i = 7; i >= 0; i--) hdr_q.push_back(len[8*i +: 8]);
    end
    if (masked)
      for (i = 3; i >= 0; i--) hdr_q.push_back(key[8*i +: 8]);
    total = hdr_q.size() + ((len > PAYLOAD_CAP) ? PAYLOAD_CAP : int'(len));
    for (i = 0; i < total; i++) begin
      if (cut_at >= 0 && i == cut_at) begin
        send_word(8'($urandom), 1'b1);
        return;
      end
      if (i < hdr_q.size()) send_word(hdr_q[i], 1'b0);
      else send_word(8'($urandom), 1'b0);
    end
  endtask

  // Mostly short payloads, now and then up to a few hundred bytes.
  function automatic logic [63:0] rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 64'($urandom_range(8));
    if (r < 85) return 64'($urandom_range(40, 9));
    if (r < 95) return 64'($urandom_range(125, 41));
    return 64'($urandom_range(300, 126));
  endfunction

  task automatic send_rand_frame(input logic fin, input logic [3:0] op);
    logic [63:0] len;
    int          enc;
    len = rand_len();
    if (len > 125 || $urandom_range(99) < 30) enc = $urandom_range(2, 1);
    else enc = 0;
    send_frame(fin, op, len, enc, 1'($urandom_range(1)), -1);
  endtask

  // A text or binary message in one to four fragments, with pings mixed in.
  // Now and then the final fragment lacks FIN, so the next message starts
  // while this one is still open.
  task automatic send_message();
    int         frags;
    int         i;
    logic [3:0] mop;
    logic       fin;
    frags = $urandom_range(4, 1);
    mop   = $urandom_range(1) ? OP_TEXT : OP_BIN;
    for (i = 0; i < frags; i++) begin
      if ($urandom_range(3) == 0) send_rand_frame(1'b1, OP_PING);
      fin = (i == frags - 1) && ($urandom_range(9) != 0);
      send_rand_frame(fin, (i == 0) ? mop : OP_CONT);
    end
  endtask

  // A frame of any opcode with a long length field, aborted by a link failure
  // early on; short lengths may still complete normally.
  task automatic send_cut_frame();
    logic [63:0] len;
    int          enc;
    enc = $urandom_range(2, 1);
    len = (enc == 1) ? 64'($urandom_range(65535)) : {$urandom, $urandom};
    send_frame(1'($urandom_range(1)), 4'($urandom_range(15)), len, enc,
               1'($urandom_range(1)), $urandom_range(24));
  endtask

  task automatic random_traffic(input int stop_at);
    int pick;
    int i;
    int n;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_message();
      end else if (pick < 63) begin
        send_rand_frame(1'($urandom_range(1)), $urandom_range(1) ? OP_PING : OP_PONG);
      end else if (pick < 69) begin
        send_rand_frame(1'($urandom_range(1)), OP_CLOSE);
      end else if (pick < 75) begin
        // Continuation outside a message: an orphan unless one is still open.
        send_rand_frame(1'($urandom_range(1)), OP_CONT);
      end else if (pick < 81) begin
        send_rand_frame(1'($urandom_range(1)),
                        4'($urandom_range(1) ? $urandom_range(7, 3) : $urandom_range(15, 11)));
      end else if (pick < 89) begin
        send_cut_frame();
      end else if (pick < 94) begin
        send_word(8'($urandom), 1'b1);
      end else begin
        // Line noise, then a link failure to bring the parser back in step.
        n = $urandom_range(6, 1);
        for (i = 0; i < n; i++) send_word(8'($urandom), 1'b0);
        send_word(8'($urandom), 1'b1);
      end
    end
  endtask

  // Short directed opening: link failure between frames, a fragmented text
  // message with a ping inside it, a binary frame that restarts the message,
  // a final continuation with a 16-bit length, an orphan continuation, an
  // unknown opcode, a close and a 64-bit length with its top bit set.
  task automatic run_directed();
    int i;
    send_word(8'h00, 1'b1);
    send_word(first_hdr(1'b0, OP_TEXT), 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(first_hdr(1'b1, OP_PING), 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h5A, 1'b0);
    send_word(first_hdr(1'b0, OP_BIN), 1'b0);
    send_word(8'h00, 1'b0);
    send_word(first_hdr(1'b1, OP_CONT), 1'b0);
    send_word({1'b0, LEN_EXT16}, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'hA5, 1'b0);
    send_word(first_hdr(1'b0, OP_CONT), 1'b0);
    send_word(8'h00, 1'b0);
    send_word(first_hdr(1'b1, OP_RSVD_TOP), 1'b0);
    send_word(8'h00, 1'b0);
    send_word(first_hdr(1'b1, OP_CLOSE), 1'b0);
    send_word(8'h00, 1'b0);
    send_word(first_hdr(1'b1, OP_BIN), 1'b0);
    send_word({1'b0, LEN_EXT64}, 1'b0);
    send_word(8'h80, 1'b0);
    for (i = 0; i < 7; i++) send_word(8'h00, 1'b0);
    send_word(8'h11, 1'b0);
    send_word(8'hFF, 1'b1);
  endtask

  // Stimulus: reset, directed words, then three stretches of random traffic
  // with different idling on each side, and finally a drain of the results.
  initial begin
    tracker = new();
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.in_byte     <= 8'h00;
    in_ch.link_failed <= 1'b0;
    src_idle_pct  = 30;
    sink_idle_pct = 74;
    words_sent    = 0;
    stall_req     = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    random_traffic(words_sent + PHASE_WORDS);

    src_idle_pct  = 74;
    sink_idle_pct = 30;
    random_traffic(words_sent + PHASE_WORDS);

    // No idling from here on. The receiver first holds off while a long
    // masked text frame keeps coming, so the deframer must stall its input.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    stall_req++;
    send_frame(1'b1, OP_TEXT, 64'd120, 0, 1'b1, -1);
    random_traffic(words_sent + PHASE_WORDS);
    in_ch.valid <= 1'b0;

    while (tracker.awaited_words.size() != 0) @(posedge clk);
    // Anything arriving after this point is flagged as unexpected.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.awaited_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_if.sv
hw/rtl/wsd_front.sv
hw/rtl/wsd_queue.sv
hw/rtl/websocket_frame_deframer.sv
hw/rtl/wsd_checker.sv
verif/tb_websocket_frame_deframer.sv
